// File: rtl/kvt_pkg.sv
// Package for the keyed value table: request codes, controller states
// and the packed entry record. No dependencies.
package kvt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  typedef enum logic [2:0] {
    OP_SET_BOOL     = 3'd0,
    OP_SET_SIGNED   = 3'd1,
    OP_SET_UNSIGNED = 3'd2,
    OP_GET          = 3'd3,
    OP_READ_AT      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_FDATA,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  kind;
    logic        bval;
    logic [31:0] sval;
    logic [31:0] uval;
  } entry_t;

endpackage

// File: rtl/kvt_ram.sv
// Entry memory of the keyed value table: one write port, one read port,
// registered read data. Depends on kvt_pkg for the entry record.
module kvt_ram #(
  parameter int DEPTH  = kvt_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output kvt_pkg::entry_t     rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  kvt_pkg::entry_t     wr_data
);

  kvt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/keyed_value_table.sv
// Keyed value table: set, get and read-at requests on up to MAX_ENTRIES entries.
// Get/set scan from position 0 to a hit or the last occupied entry; read-at fetches one
// position (no read when out of range); an unused kind goes straight to the response.
// The next request is taken in the cycle after the result loads. One request in flight;
// the scan streams one entry read per cycle through the single read port of kvt_ram.
// Reset clears count, generation and control; entries stay unwritten, no clearing pass.
module keyed_value_table #(
  parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [31:0]        in_resource_id,
  input  logic [31:0]        in_value,
  input  logic [3:0]         in_entry_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [1:0]         out_entry_kind,
  output logic [31:0]        out_entry_key,
  output logic               out_bool_value,
  output logic signed [31:0] out_signed_value,
  output logic [31:0]        out_unsigned_value,
  output logic [4:0]         out_entry_count,
  output logic [31:0]        out_change_count
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  kvt_pkg::state_t state_r, state_nxt;
  logic [2:0]       kind_r;
  logic [31:0]      key_r;
  logic [31:0]      val_r;
  logic [3:0]       pos_r;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [31:0]      gen_r, gen_nxt;
  logic             res_ok_r, res_ok_nxt;
  kvt_pkg::entry_t  res_ent_r, res_ent_nxt;

  logic             out_valid_r;
  logic             out_ok_r;
  kvt_pkg::entry_t  out_ent_r;
  logic [4:0]       out_cnt_r;
  logic [31:0]      out_gen_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  kvt_pkg::entry_t  mem_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  kvt_pkg::entry_t  upd;

  logic accept;
  logic load_out;
  logic match;
  logic scan_end;
  logic full;
  logic is_set;
  logic pos_ok;

  kvt_ram #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (upd)
  );

  assign in_stall = (state_r != kvt_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign match    = pend_r && (mem_q.key == key_r);
  assign scan_end = (issue_r >= occ_r);
  assign full     = (occ_r >= FULL_CNT);
  assign is_set   = (kind_r == kvt_pkg::OP_SET_BOOL) || (kind_r == kvt_pkg::OP_SET_SIGNED) ||
                    (kind_r == kvt_pkg::OP_SET_UNSIGNED);
  assign pos_ok   = (CMP_W'(pos_r) < CMP_W'(occ_r));

  // updated entry: existing one on a hit, a cleared one on append
  always_comb begin
    upd      = match ? mem_q : '0;
    upd.key  = key_r;
    upd.kind = kind_r[1:0];
    case (kind_r)
      kvt_pkg::OP_SET_BOOL:     upd.bval = val_r[0];
      kvt_pkg::OP_SET_SIGNED:   upd.sval = val_r;
      kvt_pkg::OP_SET_UNSIGNED: upd.uval = val_r;
      default:                  upd.uval = upd.uval;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    issue_nxt   = issue_r;
    occ_nxt     = occ_r;
    gen_nxt     = gen_r;
    res_ok_nxt  = res_ok_r;
    res_ent_nxt = res_ent_r;
    rd_en       = 1'b0;
    rd_addr     = issue_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = pend_idx_r;
    load_out    = 1'b0;
    case (state_r)
      kvt_pkg::ST_IDLE: begin
        if (accept) begin
          issue_nxt = '0;
          if (in_kind <= kvt_pkg::OP_GET) begin
            state_nxt = kvt_pkg::ST_SCAN;
          end else if (in_kind == kvt_pkg::OP_READ_AT) begin
            state_nxt = kvt_pkg::ST_FETCH;
          end else begin
            res_ok_nxt  = 1'b0;
            res_ent_nxt = '0;
            state_nxt   = kvt_pkg::ST_RESP;
          end
        end
      end
      kvt_pkg::ST_SCAN: begin
        rd_en = !scan_end;
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (match || scan_end) begin
          state_nxt = kvt_pkg::ST_RESP;
          if (is_set) begin
            if (match || !full) begin
              wr_en       = 1'b1;
              wr_addr     = match ? pend_idx_r : occ_r[IDX_W-1:0];
              occ_nxt     = match ? occ_r : occ_r + CNT_W'(1);
              gen_nxt     = gen_r + 32'd1;
              res_ok_nxt  = 1'b1;
              res_ent_nxt = upd;
            end else begin
              res_ok_nxt  = 1'b0;
              res_ent_nxt = '0;
            end
          end else begin
            res_ok_nxt  = match;
            res_ent_nxt = match ? mem_q : '0;
          end
        end
      end
      kvt_pkg::ST_FETCH: begin
        if (pos_ok) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(pos_r);
          state_nxt = kvt_pkg::ST_FDATA;
        end else begin
          res_ok_nxt  = 1'b0;
          res_ent_nxt = '0;
          state_nxt   = kvt_pkg::ST_RESP;
        end
      end
      kvt_pkg::ST_FDATA: begin
        res_ok_nxt  = 1'b1;
        res_ent_nxt = mem_q;
        state_nxt   = kvt_pkg::ST_RESP;
      end
      kvt_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = kvt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kvt_pkg::ST_IDLE;
    endcase
    pend_nxt     = rd_en;
    pend_idx_nxt = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      occ_r       <= '0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      occ_r   <= occ_nxt;
      gen_r   <= gen_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= in_resource_id;
      val_r  <= in_value;
      pos_r  <= in_entry_index;
    end
    issue_r    <= issue_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_ent_r  <= res_ent_nxt;
    if (load_out) begin
      out_ok_r  <= res_ok_r;
      out_ent_r <= res_ent_r;
      out_cnt_r <= 5'(occ_r);
      out_gen_r <= gen_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_entry_kind     = out_ent_r.kind;
  assign out_entry_key      = out_ent_r.key;
  assign out_bool_value     = out_ent_r.bval;
  assign out_signed_value   = out_ent_r.sval;
  assign out_unsigned_value = out_ent_r.uval;
  assign out_entry_count    = out_cnt_r;
  assign out_change_count   = out_gen_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy beyond table depth");

  a_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == kvt_pkg::ST_SCAN) && is_set)
    else $error("table write outside a set decision");

  a_gen_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(gen_r))
    else $error("generation moved without a write");

  a_occ_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(occ_r))
    else $error("occupancy moved without a write");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == kvt_pkg::ST_RESP)
    else $error("result loaded outside the response state");

endmodule
